@@ rtl/twe_pkg.sv @@
// twe_pkg: shared widths, defaults and types for the timestamp window expiry block.
// Used by twe_front, twe_back and time_window_expiry. No dependencies.

package twe_pkg;

   // Field widths fixed by the interface
   localparam int TS_W   = 32;
   localparam int IDX_W  = 32;
   localparam int PEAK_W = 6;

   // Default ring size (entries); one entry always stays free
   localparam int DEFAULT_WINDOW_DEPTH = 64;

   // Input queue between the front and the back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Head of the input queue as seen by the back part
   typedef struct packed {
      logic            valid;
      logic [TS_W-1:0] timestamp;
   } queue_word_type;

endpackage : twe_pkg

@@ rtl/twe_front.sv @@
// twe_front: input side; accepts request words into a short queue.
// Depends on twe_pkg. Feeds twe_back through a queue_word_type head and a pop strobe.

module twe_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [twe_pkg::TS_W-1:0] req_timestamp,
   output twe_pkg::queue_word_type  queue_head,
   input  logic                     queue_pop
);
   import twe_pkg::*;

   logic [TS_W-1:0]   queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;

   // Space check and handshake
   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign pop       = queue_pop && (count_ff != '0);

   assign queue_head.valid     = (count_ff != '0);
   assign queue_head.timestamp = queue_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, payload only
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= req_timestamp;
      end
   end

endmodule : twe_front

@@ rtl/twe_back.sv @@
// twe_back: expiry engine; timestamp ring, window bookkeeping and result register.
// Depends on twe_pkg. Takes words from twe_front's queue, drives the rsp_ channel.

module twe_back #(
   parameter int WINDOW_DEPTH = twe_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [twe_pkg::TS_W-1:0]   csr_wr_data,
   input  twe_pkg::queue_word_type    queue_head,
   output logic                       queue_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [twe_pkg::IDX_W-1:0]  rsp_item_index,
   output logic                       rsp_is_expiry,
   output logic                       rsp_forced_out,
   output logic [twe_pkg::PEAK_W-1:0] rsp_window_peak,
   output logic                       rsp_last_of_run
);
   import twe_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW_DEPTH);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CMP,
      ST_STORE
   } state_type;

   state_type           state_ff, state_in;
   logic [TS_W-1:0]     ts_ff, ts_in;
   logic [TS_W-1:0]     duration_ff, duration_in;
   logic [SLOT_W-1:0]   held_ff, held_in;
   logic [SLOT_W-1:0]   oldest_slot_ff, oldest_slot_in;
   logic [IDX_W-1:0]    oldest_index_ff, oldest_index_in;
   logic [IDX_W-1:0]    next_index_ff, next_index_in;
   logic [PEAK_W-1:0]   peak_ff, peak_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                rsp_expiry_ff, rsp_expiry_in;
   logic                rsp_forced_ff, rsp_forced_in;
   logic [PEAK_W-1:0]   rsp_peak_ff, rsp_peak_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [TS_W-1:0]     ring [WINDOW_DEPTH];
   logic [TS_W-1:0]     rd_data_ff;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_slot;
   logic [SLOT_W:0]     slot_sum;
   logic [SLOT_W-1:0]   slot_inc;

   logic                out_free;
   logic [TS_W:0]       limit;
   logic                expire_hit;
   logic                ring_full;

   // Ring addressing: next oldest slot and the slot behind the newest item
   assign slot_inc = (oldest_slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ?
                     '0 : oldest_slot_ff + 1'b1;
   assign slot_sum = {1'b0, oldest_slot_ff} + {1'b0, held_ff};
   assign wr_slot  = (slot_sum >= (SLOT_W + 1)'(WINDOW_DEPTH)) ?
                     SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW_DEPTH)) :
                     slot_sum[SLOT_W-1:0];

   // Expiry test at 33 bits so the sum never wraps
   assign limit      = {1'b0, rd_data_ff} + {1'b0, duration_ff};
   assign expire_hit = (held_ff != '0) && (limit < {1'b0, ts_ff});
   assign ring_full  = (held_ff == SLOT_W'(WINDOW_DEPTH - 1));

   // Result register may load when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: load, expire oldest entries one per cycle unless stalled, store
   always_comb begin
      state_in        = state_ff;
      ts_in           = ts_ff;
      duration_in     = csr_wr_en ? csr_wr_data : duration_ff;
      held_in         = held_ff;
      oldest_slot_in  = oldest_slot_ff;
      oldest_index_in = oldest_index_ff;
      next_index_in   = next_index_ff;
      peak_in         = peak_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_index_in    = rsp_index_ff;
      rsp_expiry_in   = rsp_expiry_ff;
      rsp_forced_in   = rsp_forced_ff;
      rsp_peak_in     = rsp_peak_ff;
      rsp_last_in     = rsp_last_ff;
      queue_pop       = 1'b0;
      wr_en           = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (queue_head.valid) begin
               queue_pop = 1'b1;
               ts_in     = queue_head.timestamp;
               if (PEAK_W'(held_ff) > peak_ff) begin
                  peak_in = PEAK_W'(held_ff);
               end
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (out_free) begin
               if (expire_hit || ring_full) begin
                  // timed-out or forced-out oldest entry
                  rsp_valid_in    = 1'b1;
                  rsp_index_in    = oldest_index_ff;
                  rsp_expiry_in   = 1'b1;
                  rsp_forced_in   = !expire_hit;
                  rsp_peak_in     = peak_ff;
                  rsp_last_in     = 1'b0;
                  oldest_slot_in  = slot_inc;
                  oldest_index_in = oldest_index_ff + 1'b1;
                  held_in         = held_ff - 1'b1;
                  if (!expire_hit) begin
                     state_in = ST_STORE;
                  end
               end else begin
                  // nothing more to expire: store and report the new item
                  wr_en         = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_index_in  = next_index_ff;
                  rsp_expiry_in = 1'b0;
                  rsp_forced_in = 1'b0;
                  rsp_peak_in   = peak_ff;
                  rsp_last_in   = 1'b1;
                  next_index_in = next_index_ff + 1'b1;
                  held_in       = held_ff + 1'b1;
                  state_in      = ST_LOAD;
               end
            end
         end
         ST_STORE: begin
            if (out_free) begin
               wr_en         = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_index_in  = next_index_ff;
               rsp_expiry_in = 1'b0;
               rsp_forced_in = 1'b0;
               rsp_peak_in   = peak_ff;
               rsp_last_in   = 1'b1;
               next_index_in = next_index_ff + 1'b1;
               held_in       = held_ff + 1'b1;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         duration_ff     <= '0;
         held_ff         <= '0;
         oldest_slot_ff  <= '0;
         oldest_index_ff <= '0;
         next_index_ff   <= '0;
         peak_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         duration_ff     <= duration_in;
         held_ff         <= held_in;
         oldest_slot_ff  <= oldest_slot_in;
         oldest_index_ff <= oldest_index_in;
         next_index_ff   <= next_index_in;
         peak_ff         <= peak_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      ts_ff         <= ts_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_expiry_ff <= rsp_expiry_in;
      rsp_forced_ff <= rsp_forced_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Timestamp ring: one write port, registered read of the oldest slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring[wr_slot] <= ts_ff;
      end
      rd_data_ff <= ring[oldest_slot_in];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item_index  = rsp_index_ff;
   assign rsp_is_expiry   = rsp_expiry_ff;
   assign rsp_forced_out  = rsp_forced_ff;
   assign rsp_window_peak = rsp_peak_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule : twe_back

@@ rtl/time_window_expiry.sv @@
// time_window_expiry: sliding-window expiry of timestamped words.
// Per request word: load it, expire oldest entries one per cycle while results drain,
// force out the oldest entry if the ring is full, then store the word and report it.
// The queue keeps taking words while the engine works; each result is registered.
// Reset (synchronous, active high) empties the queue, zeroes indices, peak and duration.
// Depends on twe_pkg, twe_front and twe_back.

module time_window_expiry #(
   parameter int WINDOW_DEPTH = twe_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [twe_pkg::TS_W-1:0]   csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [twe_pkg::TS_W-1:0]   req_timestamp,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [twe_pkg::IDX_W-1:0]  rsp_item_index,
   output logic                       rsp_is_expiry,
   output logic                       rsp_forced_out,
   output logic [twe_pkg::PEAK_W-1:0] rsp_window_peak,
   output logic                       rsp_last_of_run
);
   import twe_pkg::*;

   queue_word_type queue_head;
   logic           queue_pop;

   // Front: request queue
   twe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_timestamp (req_timestamp),
      .queue_head    (queue_head),
      .queue_pop     (queue_pop)
   );

   // Back: expiry engine
   twe_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .queue_head      (queue_head),
      .queue_pop       (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_item_index  (rsp_item_index),
      .rsp_is_expiry   (rsp_is_expiry),
      .rsp_forced_out  (rsp_forced_out),
      .rsp_window_peak (rsp_window_peak),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule : time_window_expiry
